@@ sv/c8ie_pkg.sv @@
// shared types and constants for the chip-8 instruction execute block
`timescale 1ns / 1ps
`default_nettype none
package c8ie_pkg;

    localparam int C8_MEM_BYTES   = 4096;
    localparam int C8_STACK_DEPTH = 16;
    localparam int SCREEN_W       = 64;
    localparam int SCREEN_H       = 32;
    localparam int ROW_W          = $clog2(SCREEN_H);
    localparam int ALU_W          = 17;

    localparam logic [1:0] CMD_EXEC  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_ROW   = 2'd2;

    localparam logic [3:0] OP_SYS   = 4'h0;
    localparam logic [3:0] OP_JP    = 4'h1;
    localparam logic [3:0] OP_CALL  = 4'h2;
    localparam logic [3:0] OP_SEI   = 4'h3;
    localparam logic [3:0] OP_SNEI  = 4'h4;
    localparam logic [3:0] OP_SER   = 4'h5;
    localparam logic [3:0] OP_LDI   = 4'h6;
    localparam logic [3:0] OP_ADDI  = 4'h7;
    localparam logic [3:0] OP_ALU   = 4'h8;
    localparam logic [3:0] OP_SNER  = 4'h9;
    localparam logic [3:0] OP_LDIDX = 4'hA;
    localparam logic [3:0] OP_JPV0  = 4'hB;
    localparam logic [3:0] OP_RND   = 4'hC;
    localparam logic [3:0] OP_DRW   = 4'hD;
    localparam logic [3:0] OP_KEY   = 4'hE;
    localparam logic [3:0] OP_MISC  = 4'hF;

    localparam logic [15:0] OPC_CLS = 16'h00E0;
    localparam logic [15:0] OPC_RET = 16'h00EE;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [7:0] KEY_DOWN = 8'h9E;
    localparam logic [7:0] KEY_UP   = 8'hA1;

    localparam logic [7:0] FX_GET_DT = 8'h07;
    localparam logic [7:0] FX_WAITK  = 8'h0A;
    localparam logic [7:0] FX_SET_DT = 8'h15;
    localparam logic [7:0] FX_SET_ST = 8'h18;
    localparam logic [7:0] FX_ADD_I  = 8'h1E;
    localparam logic [7:0] FX_FONT   = 8'h29;
    localparam logic [7:0] FX_BCD    = 8'h33;
    localparam logic [7:0] FX_DUMP   = 8'h55;
    localparam logic [7:0] FX_LOAD   = 8'h65;

    localparam logic [7:0] BCD_HUNDRED = 8'd100;
    localparam logic [7:0] BCD_TEN     = 8'd10;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EXEC, ST_SKIP, ST_REDUCE, ST_MEMW, ST_CLEAR,
        ST_DRAW_RD, ST_DRAW_WR, ST_BCD_SUB, ST_BCD_WR, ST_BCD_LAST,
        ST_DUMP, ST_LOAD_RD, ST_LOAD_WR, ST_FIN, ST_DONE
    } t_state;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             carry;
    } t_alu_rsp;

endpackage
`default_nettype wire

@@ sv/c8ie_if.sv @@
// command and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface c8ie_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] instruction;
    logic [11:0] address;
    logic [7:0]  write_byte;
    logic [15:0] key_mask;
    logic [3:0]  key_code;
    logic [7:0]  random_byte;
    logic [7:0]  timer_now;
    modport source (output valid, command, instruction, address, write_byte, key_mask,
                    key_code, random_byte, timer_now, input ready);
    modport sink (input valid, command, instruction, address, write_byte, key_mask,
                  key_code, random_byte, timer_now, output ready);
endinterface

interface c8ie_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] program_counter;
    logic [15:0] index_value;
    logic [7:0]  flag_value;
    logic        redraw;
    logic [63:0] row_pixels;
    logic        delay_load;
    logic        sound_load;
    logic [7:0]  timer_value_out;
    logic        stack_fault;
    modport source (output valid, program_counter, index_value, flag_value, redraw,
                    row_pixels, delay_load, sound_load, timer_value_out, stack_fault,
                    input ready);
    modport sink (input valid, program_counter, index_value, flag_value, redraw,
                  row_pixels, delay_load, sound_load, timer_value_out, stack_fault,
                  output ready);
endinterface
`default_nettype wire

@@ sv/c8ie_ram.sv @@
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module c8ie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

@@ sv/c8ie_alu.sv @@
// shared add and subtract unit
`timescale 1ns / 1ps
`default_nettype none
module c8ie_alu
    import c8ie_pkg::*;
(
    input  wire t_alu_req i_req,
    output t_alu_rsp      o_rsp
);
    logic [ALU_W:0] w_res;

    assign w_res = i_req.sub ? ({1'b0, i_req.a} - {1'b0, i_req.b})
                             : ({1'b0, i_req.a} + {1'b0, i_req.b});
    assign o_rsp.sum   = w_res[ALU_W-1:0];
    assign o_rsp.carry = w_res[ALU_W];
endmodule
`default_nettype wire

@@ sv/chip8_instruction_execute.sv @@
// chip-8 instruction execute unit top level
`timescale 1ns / 1ps
`default_nettype none
// Executes one CHIP-8 instruction, memory byte write or display row read per input
// transaction and returns one result transaction. Adds, subtracts, equality compares,
// memory address wrapping and BCD digit extraction go through one shared 17-bit
// add/subtract unit under a sequencer; the block takes a new transaction only when
// back in idle. 00E0 clears the display one row a cycle. Memory writes, sprite
// draws, FX33, FX55 and FX65 first reduce the address modulo MEM_BYTES by repeated
// subtraction, then step through the memory port (one access per cycle, registered
// read). Byte memory has no reset; the display and registers clear on reset.
module chip8_instruction_execute
    import c8ie_pkg::*;
#(
    parameter int MEM_BYTES   = C8_MEM_BYTES,
    parameter int STACK_DEPTH = C8_STACK_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    c8ie_in_if.sink   i_cmd,
    c8ie_out_if.source o_res
);
    localparam int AW        = $clog2(MEM_BYTES);
    localparam int SIW       = $clog2(STACK_DEPTH);
    localparam int SPW       = $clog2(STACK_DEPTH + 1);
    localparam int RED_STEPS = 17 - AW;
    localparam int RSW       = $clog2(RED_STEPS + 1);
    localparam logic [ALU_W-1:0] MEM_LIM = ALU_W'(MEM_BYTES);

    t_state r_state, n_state, r_ret;

    logic [7:0]        r_v [16];
    logic [11:0]       r_pc;
    logic [15:0]       r_i;
    logic [SPW-1:0]    r_sp;
    logic [11:0]       r_stack [STACK_DEPTH];
    logic [63:0]       r_frame [SCREEN_H];

    logic [1:0]        r_cmd;
    logic [15:0]       r_op;
    logic [7:0]        r_wbyte;
    logic [15:0]       r_keys;
    logic [3:0]        r_key;
    logic [7:0]        r_rand;
    logic [7:0]        r_tnow;

    logic [ALU_W-1:0]  r_acc;
    logic [RSW-1:0]    r_step;
    logic [AW-1:0]     r_ma;
    logic [4:0]        r_cnt;
    logic              r_hit;
    logic [7:0]        r_bcd;
    logic [3:0]        r_dig;
    logic              r_tens;

    logic              r_redraw, r_fault, r_dl, r_sl;
    logic [7:0]        r_tv;
    logic [63:0]       r_row;
    logic              r_ovalid;

    t_alu_req          w_req;
    t_alu_rsp          w_rsp;
    logic              w_ram_we;
    logic [AW-1:0]     w_ram_addr;
    logic [7:0]        w_ram_wdata, w_ram_rdata;

    logic [3:0]        w_x, w_y, w_n;
    logic [7:0]        w_nn, w_vx, w_vy;
    logic [11:0]       w_nnn;
    logic              w_zero, w_ge, w_down, w_skip;
    logic [AW-1:0]     w_ma_inc;
    logic [ALU_W-1:0]  w_red;
    logic [SPW-1:0]    w_spm1;
    logic [63:0]       w_mask;
    logic [ROW_W-1:0]  w_fy;
    logic [5:0]        w_sh;
    logic              w_accept, w_out_load;

    assign w_x    = r_op[11:8];
    assign w_y    = r_op[7:4];
    assign w_n    = r_op[3:0];
    assign w_nn   = r_op[7:0];
    assign w_nnn  = r_op[11:0];
    assign w_vx   = r_v[w_x];
    assign w_vy   = r_v[w_y];
    assign w_zero = (w_rsp.sum == '0);
    assign w_ge   = !w_rsp.carry;
    assign w_down = (w_vx < 8'd16) && r_keys[w_vx[3:0]];
    assign w_ma_inc = (w_rsp.sum == MEM_LIM) ? '0 : w_rsp.sum[AW-1:0];
    assign w_red  = w_ge ? w_rsp.sum : r_acc;
    assign w_spm1 = r_sp - SPW'(1);
    assign w_sh   = w_vx[5:0];
    assign w_mask = ({w_ram_rdata, 56'd0} >> w_sh) | ({w_ram_rdata, 56'd0} << (7'd64 - {1'b0, w_sh}));
    assign w_fy   = w_vy[ROW_W-1:0] + r_cnt[ROW_W-1:0];

    assign w_accept   = i_cmd.valid && i_cmd.ready;
    assign w_out_load = (r_state == ST_DONE) && (!r_ovalid || o_res.ready);
    assign i_cmd.ready = (r_state == ST_IDLE);

    c8ie_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    c8ie_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    // shared unit operand selection and memory port
    always_comb begin
        w_req       = '0;
        w_ram_we    = 1'b0;
        w_ram_addr  = r_ma;
        w_ram_wdata = r_v[r_cnt[3:0]];
        case (r_state)
            ST_EXEC: begin
                case (r_op[15:12])
                    OP_SEI, OP_SNEI: w_req = '{ALU_W'(w_vx), ALU_W'(w_nn), 1'b1};
                    OP_SER, OP_SNER: w_req = '{ALU_W'(w_vx), ALU_W'(w_vy), 1'b1};
                    OP_ADDI:         w_req = '{ALU_W'(w_vx), ALU_W'(w_nn), 1'b0};
                    OP_ALU: begin
                        if (w_n == ALU_SBN) w_req = '{ALU_W'(w_vy), ALU_W'(w_vx), 1'b1};
                        else w_req = '{ALU_W'(w_vx), ALU_W'(w_vy), w_n == ALU_SUB};
                    end
                    OP_JPV0:         w_req = '{ALU_W'(r_v[0]), ALU_W'(w_nnn), 1'b0};
                    OP_MISC: begin
                        if (w_nn == FX_FONT) w_req = '{ALU_W'({w_vx, 2'b00}), ALU_W'(w_vx), 1'b0};
                        else w_req = '{ALU_W'(r_i), ALU_W'(w_vx), 1'b0};
                    end
                    default: w_req = '0;
                endcase
            end
            ST_SKIP:   w_req = '{ALU_W'(r_pc), ALU_W'(2), 1'b0};
            ST_REDUCE: w_req = '{r_acc, MEM_LIM << r_step, 1'b1};
            ST_MEMW: begin
                w_ram_we    = 1'b1;
                w_ram_wdata = r_wbyte;
            end
            ST_DUMP: begin
                w_req    = '{ALU_W'(r_ma), ALU_W'(1), 1'b0};
                w_ram_we = 1'b1;
            end
            ST_DRAW_RD, ST_LOAD_RD: w_req = '{ALU_W'(r_ma), ALU_W'(1), 1'b0};
            ST_BCD_SUB: w_req = '{ALU_W'(r_bcd), ALU_W'(r_tens ? BCD_TEN : BCD_HUNDRED), 1'b1};
            ST_BCD_WR: begin
                w_req       = '{ALU_W'(r_ma), ALU_W'(1), 1'b0};
                w_ram_we    = 1'b1;
                w_ram_wdata = {4'd0, r_dig};
            end
            ST_BCD_LAST: begin
                w_ram_we    = 1'b1;
                w_ram_wdata = r_bcd;
            end
            ST_FIN: w_req = '{ALU_W'(r_i), ALU_W'({1'b0, w_x} + 5'd1), 1'b0};
            default: w_req = '0;
        endcase
    end

    // skip decision for conditional instructions
    always_comb begin
        case (r_op[15:12])
            OP_SEI:  w_skip = w_zero;
            OP_SNEI: w_skip = !w_zero;
            OP_SER:  w_skip = (w_n == 4'd0) && w_zero;
            OP_SNER: w_skip = (w_n == 4'd0) && !w_zero;
            OP_KEY:  w_skip = ((w_nn == KEY_DOWN) && w_down) || ((w_nn == KEY_UP) && !w_down);
            default: w_skip = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_cmd.command)
                        CMD_EXEC:  n_state = ST_EXEC;
                        CMD_WRITE: n_state = ST_REDUCE;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_EXEC: begin
                n_state = ST_DONE;
                case (r_op[15:12])
                    OP_SYS:  if (r_op == OPC_CLS) n_state = ST_CLEAR;
                    OP_SEI, OP_SNEI, OP_SER, OP_SNER, OP_KEY: begin
                        if (w_skip) n_state = ST_SKIP;
                    end
                    OP_DRW:  if (w_n != 4'd0) n_state = ST_REDUCE;
                    OP_MISC: begin
                        if (w_nn == FX_BCD || w_nn == FX_DUMP || w_nn == FX_LOAD)
                            n_state = ST_REDUCE;
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_SKIP:    n_state = ST_DONE;
            ST_REDUCE:  if (r_step == '0) n_state = r_ret;
            ST_MEMW:    n_state = ST_DONE;
            ST_CLEAR:   if (r_cnt == 5'(SCREEN_H - 1)) n_state = ST_DONE;
            ST_DRAW_RD: n_state = ST_DRAW_WR;
            ST_DRAW_WR: n_state = ((r_cnt[3:0] + 4'd1) == w_n) ? ST_DONE : ST_DRAW_RD;
            ST_BCD_SUB: if (!w_ge) n_state = ST_BCD_WR;
            ST_BCD_WR:  n_state = r_tens ? ST_BCD_LAST : ST_BCD_SUB;
            ST_BCD_LAST: n_state = ST_DONE;
            ST_DUMP:    if (r_cnt[3:0] == w_x) n_state = ST_FIN;
            ST_LOAD_RD: n_state = ST_LOAD_WR;
            ST_LOAD_WR: n_state = (r_cnt[3:0] == w_x) ? ST_FIN : ST_LOAD_RD;
            ST_FIN:     n_state = ST_DONE;
            ST_DONE:    if (w_out_load) n_state = ST_IDLE;
        endcase
    end

    // architectural state and work registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) r_v[k] <= '0;
            for (int k = 0; k < SCREEN_H; k++) r_frame[k] <= '0;
            r_pc     <= '0;
            r_i      <= '0;
            r_sp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_out_load) r_ovalid <= 1'b1;
            else if (o_res.valid && o_res.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_cmd    <= i_cmd.command;
                        r_op     <= i_cmd.instruction;
                        r_wbyte  <= i_cmd.write_byte;
                        r_keys   <= i_cmd.key_mask;
                        r_key    <= i_cmd.key_code;
                        r_rand   <= i_cmd.random_byte;
                        r_tnow   <= i_cmd.timer_now;
                        r_redraw <= 1'b0;
                        r_fault  <= 1'b0;
                        r_dl     <= 1'b0;
                        r_sl     <= 1'b0;
                        r_tv     <= '0;
                        r_row    <= (i_cmd.command == CMD_ROW)
                                    ? r_frame[i_cmd.address[ROW_W-1:0]] : '0;
                        r_acc    <= ALU_W'(i_cmd.address);
                        r_step   <= RSW'(RED_STEPS - 1);
                        r_ret    <= ST_MEMW;
                    end
                end
                ST_EXEC: begin
                    r_acc  <= ALU_W'(r_i);
                    r_step <= RSW'(RED_STEPS - 1);
                    r_cnt  <= '0;
                    r_hit  <= 1'b0;
                    r_bcd  <= w_vx;
                    r_dig  <= '0;
                    r_tens <= 1'b0;
                    case (r_op[15:12])
                        OP_SYS: begin
                            if (r_op == OPC_RET) begin
                                if (r_sp == '0) r_fault <= 1'b1;
                                else begin
                                    r_sp <= w_spm1;
                                    r_pc <= r_stack[w_spm1[SIW-1:0]];
                                end
                            end
                        end
                        OP_JP:    r_pc <= w_nnn;
                        OP_CALL: begin
                            if (r_sp >= SPW'(STACK_DEPTH)) r_fault <= 1'b1;
                            else begin
                                r_stack[r_sp[SIW-1:0]] <= r_pc;
                                r_sp <= r_sp + SPW'(1);
                                r_pc <= w_nnn;
                            end
                        end
                        OP_LDI:   r_v[w_x] <= w_nn;
                        OP_ADDI:  r_v[w_x] <= w_rsp.sum[7:0];
                        OP_ALU: begin
                            // with vf as destination the result wins over the flag
                            case (w_n)
                                ALU_MOV: r_v[w_x] <= w_vy;
                                ALU_OR:  r_v[w_x] <= w_vx | w_vy;
                                ALU_AND: r_v[w_x] <= w_vx & w_vy;
                                ALU_XOR: r_v[w_x] <= w_vx ^ w_vy;
                                ALU_ADD: begin
                                    if (w_x != 4'hF) r_v[15] <= {7'd0, w_rsp.sum[8]};
                                    r_v[w_x] <= w_rsp.sum[7:0];
                                end
                                ALU_SUB, ALU_SBN: begin
                                    if (w_x != 4'hF) r_v[15] <= {7'd0, w_ge};
                                    r_v[w_x] <= w_rsp.sum[7:0];
                                end
                                ALU_SHR: begin
                                    if (w_x != 4'hF) r_v[15] <= {7'd0, w_vx[0]};
                                    r_v[w_x] <= {1'b0, w_vx[7:1]};
                                end
                                ALU_SHL: begin
                                    if (w_x != 4'hF) r_v[15] <= {7'd0, w_vx[7]};
                                    r_v[w_x] <= {w_vx[6:0], 1'b0};
                                end
                                default: ;
                            endcase
                        end
                        OP_LDIDX: r_i <= {4'd0, w_nnn};
                        OP_JPV0:  r_pc <= w_rsp.sum[11:0];
                        OP_RND:   r_v[w_x] <= r_rand & w_nn;
                        OP_DRW: begin
                            r_redraw <= 1'b1;
                            r_ret    <= ST_DRAW_RD;
                            if (w_n == 4'd0) r_v[15] <= '0;
                        end
                        OP_MISC: begin
                            case (w_nn)
                                FX_GET_DT: r_v[w_x] <= r_tnow;
                                FX_WAITK:  r_v[w_x] <= {4'd0, r_key};
                                FX_SET_DT: begin
                                    r_dl <= 1'b1;
                                    r_tv <= w_vx;
                                end
                                FX_SET_ST: begin
                                    r_sl <= 1'b1;
                                    r_tv <= w_vx;
                                end
                                FX_ADD_I, FX_FONT: r_i <= w_rsp.sum[15:0];
                                FX_BCD:  r_ret <= ST_BCD_SUB;
                                FX_DUMP: r_ret <= ST_DUMP;
                                FX_LOAD: r_ret <= ST_LOAD_RD;
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
                ST_SKIP: r_pc <= w_rsp.sum[11:0];
                ST_REDUCE: begin
                    r_acc  <= w_red;
                    r_ma   <= w_red[AW-1:0];
                    r_step <= r_step - RSW'(1);
                end
                ST_CLEAR: begin
                    r_frame[r_cnt[ROW_W-1:0]] <= '0;
                    r_cnt <= r_cnt + 5'd1;
                end
                ST_DRAW_RD, ST_LOAD_RD: r_ma <= w_ma_inc;
                ST_DRAW_WR: begin
                    // vf is written with the last row so vx and vy stay intact for every row
                    r_frame[w_fy] <= r_frame[w_fy] ^ w_mask;
                    r_hit <= r_hit | ((r_frame[w_fy] & w_mask) != '0);
                    if ((r_cnt[3:0] + 4'd1) == w_n)
                        r_v[15] <= {7'd0, r_hit | ((r_frame[w_fy] & w_mask) != '0)};
                    r_cnt <= r_cnt + 5'd1;
                end
                ST_BCD_SUB: begin
                    if (w_ge) begin
                        r_bcd <= w_rsp.sum[7:0];
                        r_dig <= r_dig + 4'd1;
                    end
                end
                ST_BCD_WR: begin
                    r_ma   <= w_ma_inc;
                    r_dig  <= '0;
                    r_tens <= 1'b1;
                end
                ST_DUMP: begin
                    r_ma  <= w_ma_inc;
                    r_cnt <= r_cnt + 5'd1;
                end
                ST_LOAD_WR: begin
                    r_v[r_cnt[3:0]] <= w_ram_rdata;
                    r_cnt <= r_cnt + 5'd1;
                end
                ST_FIN: r_i <= w_rsp.sum[15:0];
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            o_res.program_counter <= r_pc;
            o_res.index_value     <= r_i;
            o_res.flag_value      <= r_v[15];
            o_res.redraw          <= r_redraw;
            o_res.row_pixels      <= r_row;
            o_res.delay_load      <= r_dl;
            o_res.sound_load      <= r_sl;
            o_res.timer_value_out <= r_tv;
            o_res.stack_fault     <= r_fault;
        end
    end

    assign o_res.valid = r_ovalid;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ST_IDLE))
        else $error("idle right after accepting a transaction");

    a_hold_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_ovalid && !o_res.ready) |=> (r_state == ST_DONE))
        else $error("result overwritten while stalled");

    a_cmd_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MEMW) |-> (r_cmd == CMD_WRITE))
        else $error("memory write state without write command");
endmodule
`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for the chip-8 instruction execute block
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import c8ie_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 60;
    localparam int FILL_LOW = 112;
    localparam int FILL_HIGH = 16;
    localparam int PHASE_ITEMS = 100;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] instruction;
        logic [11:0] address;
        logic [7:0]  write_byte;
        logic [15:0] key_mask;
        logic [3:0]  key_code;
        logic [7:0]  random_byte;
        logic [7:0]  timer_now;
    } t_cmd;

    typedef struct packed {
        logic [11:0] program_counter;
        logic [15:0] index_value;
        logic [7:0]  flag_value;
        logic        redraw;
        logic [63:0] row_pixels;
        logic        delay_load;
        logic        sound_load;
        logic [7:0]  timer_value_out;
        logic        stack_fault;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    c8ie_in_if  cmd_ch ();
    c8ie_out_if res_ch ();

    chip8_instruction_execute i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_res   (res_ch.source)
    );

    // shadow machine state
    logic [7:0]  v_reg [16];
    logic [11:0] pc_q;
    logic [15:0] idx_q;
    logic [11:0] call_stack [C8_STACK_DEPTH];
    int          sp_q;
    logic [7:0]  mem_q [C8_MEM_BYTES];
    logic        mem_ok [C8_MEM_BYTES];
    logic [63:0] screen [SCREEN_H];

    t_res expected_results [$];
    int   errors = 0;
    int   sent = 0;
    int   received = 0;
    int   draws = 0;
    int   faults = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   idle_cycles = 0;

    task automatic execute_op(input t_cmd c, inout t_res r);
        logic [15:0] op;
        logic [3:0]  x, y, n;
        logic [7:0]  nn, vx, vy, bits;
        logic [8:0]  wide;
        logic        skip, down, hit;
        int          fx, fy;
        op = c.instruction;
        x = op[11:8];
        y = op[7:4];
        n = op[3:0];
        nn = op[7:0];
        vx = v_reg[x];
        vy = v_reg[y];
        skip = 1'b0;
        case (op[15:12])
            OP_SYS: begin
                if (op == OPC_CLS) begin
                    for (int i = 0; i < SCREEN_H; i++) screen[i] = '0;
                end else if (op == OPC_RET) begin
                    if (sp_q == 0) begin
                        r.stack_fault = 1'b1;
                    end else begin
                        sp_q--;
                        pc_q = call_stack[sp_q];
                    end
                end
            end
            OP_JP: pc_q = op[11:0];
            OP_CALL: begin
                if (sp_q >= C8_STACK_DEPTH) begin
                    r.stack_fault = 1'b1;
                end else begin
                    call_stack[sp_q] = pc_q;
                    sp_q++;
                    pc_q = op[11:0];
                end
            end
            OP_SEI: skip = (vx == nn);
            OP_SNEI: skip = (vx != nn);
            OP_SER: if (n == 0) skip = (vx == vy);
            OP_LDI: v_reg[x] = nn;
            OP_ADDI: v_reg[x] = vx + nn;
            OP_ALU: begin
                case (n)
                    ALU_MOV: v_reg[x] = vy;
                    ALU_OR: v_reg[x] = vx | vy;
                    ALU_AND: v_reg[x] = vx & vy;
                    ALU_XOR: v_reg[x] = vx ^ vy;
                    ALU_ADD: begin
                        wide = {1'b0, vx} + {1'b0, vy};
                        v_reg[15] = {7'd0, wide[8]};
                        v_reg[x] = wide[7:0];
                    end
                    ALU_SUB: begin
                        v_reg[15] = {7'd0, vx >= vy};
                        v_reg[x] = vx - vy;
                    end
                    ALU_SHR: begin
                        v_reg[15] = {7'd0, vx[0]};
                        v_reg[x] = vx >> 1;
                    end
                    ALU_SBN: begin
                        v_reg[15] = {7'd0, vy >= vx};
                        v_reg[x] = vy - vx;
                    end
                    ALU_SHL: begin
                        v_reg[15] = {7'd0, vx[7]};
                        v_reg[x] = vx << 1;
                    end
                    default: ;
                endcase
            end
            OP_SNER: if (n == 0) skip = (vx != vy);
            OP_LDIDX: idx_q = {4'd0, op[11:0]};
            OP_JPV0: pc_q = v_reg[0] + op[11:0];
            OP_RND: v_reg[x] = c.random_byte & nn;
            OP_DRW: begin
                hit = 1'b0;
                for (int row = 0; row < n; row++) begin
                    bits = mem_q[(int'(idx_q) + row) % C8_MEM_BYTES];
                    fy = (int'(vy) + row) % SCREEN_H;
                    for (int col = 0; col < 8; col++) begin
                        if (bits[7 - col]) begin
                            fx = (int'(vx) + col) % SCREEN_W;
                            if (screen[fy][63 - fx]) hit = 1'b1;
                            screen[fy][63 - fx] = ~screen[fy][63 - fx];
                        end
                    end
                end
                v_reg[15] = {7'd0, hit};
                r.redraw = 1'b1;
            end
            OP_KEY: begin
                down = (vx < 16) && c.key_mask[vx[3:0]];
                if (nn == KEY_DOWN) skip = down;
                else if (nn == KEY_UP) skip = !down;
            end
            default: begin
                case (nn)
                    FX_GET_DT: v_reg[x] = c.timer_now;
                    FX_WAITK: v_reg[x] = {4'd0, c.key_code};
                    FX_SET_DT: begin
                        r.delay_load = 1'b1;
                        r.timer_value_out = vx;
                    end
                    FX_SET_ST: begin
                        r.sound_load = 1'b1;
                        r.timer_value_out = vx;
                    end
                    FX_ADD_I: idx_q = idx_q + vx;
                    FX_FONT: idx_q = 16'(vx * 5);
                    FX_BCD: begin
                        mem_q[(int'(idx_q)) % C8_MEM_BYTES] = vx / 100;
                        mem_q[(int'(idx_q) + 1) % C8_MEM_BYTES] = (vx / 10) % 10;
                        mem_q[(int'(idx_q) + 2) % C8_MEM_BYTES] = vx % 10;
                        for (int i = 0; i < 3; i++)
                            mem_ok[(int'(idx_q) + i) % C8_MEM_BYTES] = 1'b1;
                    end
                    FX_DUMP: begin
                        for (int i = 0; i <= x; i++) begin
                            mem_q[(int'(idx_q) + i) % C8_MEM_BYTES] = v_reg[i];
                            mem_ok[(int'(idx_q) + i) % C8_MEM_BYTES] = 1'b1;
                        end
                        idx_q = idx_q + x + 1;
                    end
                    FX_LOAD: begin
                        for (int i = 0; i <= x; i++)
                            v_reg[i] = mem_q[(int'(idx_q) + i) % C8_MEM_BYTES];
                        idx_q = idx_q + x + 1;
                    end
                    default: ;
                endcase
            end
        endcase
        if (skip) pc_q = pc_q + 12'd2;
    endtask

    task automatic predict_step(input t_cmd c);
        t_res r;
        r = '0;
        case (c.command)
            CMD_EXEC: execute_op(c, r);
            CMD_WRITE: begin
                mem_q[c.address] = c.write_byte;
                mem_ok[c.address] = 1'b1;
            end
            CMD_ROW: r.row_pixels = screen[c.address % SCREEN_H];
            default: ;
        endcase
        r.program_counter = pc_q;
        r.index_value = idx_q;
        r.flag_value = v_reg[15];
        if (r.redraw) draws++;
        if (r.stack_fault) faults++;
        expected_results.push_back(r);
    endtask

    task automatic send_item(input t_cmd c);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(6, 1) : 0;
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.command     <= c.command;
        cmd_ch.instruction <= c.instruction;
        cmd_ch.address     <= c.address;
        cmd_ch.write_byte  <= c.write_byte;
        cmd_ch.key_mask    <= c.key_mask;
        cmd_ch.key_code    <= c.key_code;
        cmd_ch.random_byte <= c.random_byte;
        cmd_ch.timer_now   <= c.timer_now;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        predict_step(c);
        sent++;
    endtask

    function automatic t_cmd rand_fields();
        t_cmd c;
        c.command = CMD_EXEC;
        c.instruction = 16'($urandom);
        c.address = 12'($urandom);
        c.write_byte = 8'($urandom);
        c.key_mask = 16'($urandom);
        c.key_code = 4'($urandom);
        c.random_byte = 8'($urandom);
        c.timer_now = 8'($urandom);
        return c;
    endfunction

    // true when every byte the opcode reads has been written
    function automatic logic reads_ok(input logic [15:0] op);
        int cnt;
        cnt = 0;
        if (op[15:12] == OP_DRW) cnt = int'(op[3:0]);
        else if (op[15:12] == OP_MISC && op[7:0] == FX_LOAD) cnt = int'(op[11:8]) + 1;
        for (int k = 0; k < cnt; k++)
            if (!mem_ok[(int'(idx_q) + k) % C8_MEM_BYTES]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic send_op(input logic [15:0] op);
        t_cmd c;
        c = rand_fields();
        c.instruction = op;
        send_item(c);
    endtask

    task automatic test_memory_fill();
        t_cmd c;
        for (int a = 0; a < FILL_LOW + FILL_HIGH; a++) begin
            c = rand_fields();
            c.command = CMD_WRITE;
            c.address = (a < FILL_LOW) ? 12'(a)
                                       : 12'(C8_MEM_BYTES - FILL_LOW - FILL_HIGH + a);
            send_item(c);
        end
    endtask

    task automatic test_directed();
        t_cmd c;
        send_op({OP_LDI, 4'h1, 8'hFF});
        send_op({OP_LDI, 4'h2, 8'h01});
        send_op({OP_ALU, 4'h1, 4'h2, ALU_ADD});
        send_op({OP_ALU, 4'h2, 4'h1, ALU_SUB});
        send_op({OP_LDI, 4'hF, 8'h81});
        send_op({OP_ALU, 4'hF, 4'h0, ALU_SHL});
        send_op({OP_LDI, 4'h3, 8'h3E});
        send_op({OP_ALU, 4'h3, 4'h0, ALU_SHR});
        send_op({OP_ALU, 4'h3, 4'h2, ALU_SBN});
        send_op({OP_LDIDX, 12'hFFE});
        send_op({OP_LDI, 4'h4, 8'd60});
        send_op({OP_LDI, 4'h5, 8'd30});
        send_op({OP_DRW, 4'h4, 4'h5, 4'hF});
        send_op({OP_DRW, 4'h4, 4'h5, 4'hF});
        send_op({OP_DRW, 4'h4, 4'h5, 4'h0});
        send_op({OP_LDI, 4'h6, 8'd200});
        send_op({OP_KEY, 4'h6, KEY_DOWN});
        send_op({OP_KEY, 4'h6, KEY_UP});
        send_op({OP_MISC, 4'h6, FX_BCD});
        send_op({OP_MISC, 4'hF, FX_DUMP});
        send_op({OP_MISC, 4'hF, FX_LOAD});
        send_op({OP_JPV0, 12'hFFF});
        send_op(OPC_CLS);
        c = rand_fields();
        c.command = CMD_ROW;
        c.address = 12'hFFF;
        send_item(c);
        c.command = CMD_NONE;
        send_item(c);
    endtask

    task automatic test_stack();
        send_op(OPC_RET);
        for (int i = 0; i <= C8_STACK_DEPTH; i++) send_op({OP_CALL, 12'($urandom)});
        for (int i = 0; i <= C8_STACK_DEPTH; i++) send_op(OPC_RET);
    endtask

    function automatic logic [15:0] random_op();
        logic [15:0] op;
        logic [3:0]  n;
        op = 16'($urandom);
        n = op[3:0];
        case (op[15:12])
            OP_SYS: begin
                case ($urandom_range(3))
                    0: op = OPC_CLS;
                    1, 2: op = OPC_RET;
                    default: ;
                endcase
            end
            OP_SER, OP_SNER: if ($urandom_range(3) != 0) op[3:0] = 4'h0;
            OP_ALU: if ($urandom_range(4) != 0) op[3:0] = (n > 4'h7) ? ALU_SHL : n;
            OP_DRW: if ($urandom_range(3) == 0) op[3:0] = 4'($urandom_range(3));
            OP_KEY: begin
                case ($urandom_range(4))
                    0, 1: op[7:0] = KEY_DOWN;
                    2, 3: op[7:0] = KEY_UP;
                    default: ;
                endcase
            end
            OP_MISC: begin
                case ($urandom_range(9))
                    0: op[7:0] = FX_GET_DT;
                    1: op[7:0] = FX_WAITK;
                    2: op[7:0] = FX_SET_DT;
                    3: op[7:0] = FX_SET_ST;
                    4: op[7:0] = FX_ADD_I;
                    5: op[7:0] = FX_FONT;
                    6: op[7:0] = FX_BCD;
                    7: op[7:0] = FX_DUMP;
                    8: op[7:0] = FX_LOAD;
                    default: ;
                endcase
            end
            default: ;
        endcase
        return op;
    endfunction

    task automatic test_random(input int count, input int idle, input int stall);
        t_cmd c;
        int pick;
        idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < count; i++) begin
            c = rand_fields();
            pick = $urandom_range(99);
            if (pick < 8) c.command = CMD_WRITE;
            else if (pick < 16) c.command = CMD_ROW;
            else if (pick < 18) c.command = CMD_NONE;
            else begin
                c.instruction = random_op();
                // point the index back into preloaded memory before an unsafe read
                if (!reads_ok(c.instruction))
                    c.instruction = {OP_LDIDX, 12'($urandom_range(FILL_LOW - 16))};
            end
            send_item(c);
        end
    endtask

    // result side
    always @(posedge i_clk) begin
        if (!i_rst_n) res_ch.ready <= 1'b0;
        else res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            received++;
            if (expected_results.size() == 0) begin
                $error("result transaction with no command outstanding");
                errors++;
            end else begin
                e = expected_results.pop_front();
                check_field("program_counter", 64'(e.program_counter),
                            64'(res_ch.program_counter));
                check_field("index_value", 64'(e.index_value), 64'(res_ch.index_value));
                check_field("flag_value", 64'(e.flag_value), 64'(res_ch.flag_value));
                check_field("redraw", 64'(e.redraw), 64'(res_ch.redraw));
                check_field("row_pixels", e.row_pixels, res_ch.row_pixels);
                check_field("delay_load", 64'(e.delay_load), 64'(res_ch.delay_load));
                check_field("sound_load", 64'(e.sound_load), 64'(res_ch.sound_load));
                check_field("timer_value_out", 64'(e.timer_value_out),
                            64'(res_ch.timer_value_out));
                check_field("stack_fault", 64'(e.stack_fault), 64'(res_ch.stack_fault));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        cmd_ch.valid <= 1'b0;
        cmd_ch.command <= CMD_EXEC;
        cmd_ch.instruction <= '0;
        cmd_ch.address <= '0;
        cmd_ch.write_byte <= '0;
        cmd_ch.key_mask <= '0;
        cmd_ch.key_code <= '0;
        cmd_ch.random_byte <= '0;
        cmd_ch.timer_now <= '0;
        for (int i = 0; i < 16; i++) v_reg[i] = '0;
        for (int i = 0; i < SCREEN_H; i++) screen[i] = '0;
        for (int i = 0; i < C8_STACK_DEPTH; i++) call_stack[i] = '0;
        for (int i = 0; i < C8_MEM_BYTES; i++) begin
            mem_q[i] = '0;
            mem_ok[i] = 1'b0;
        end
        pc_q = '0;
        idx_q = '0;
        sp_q = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_memory_fill();
        test_directed();
        test_stack();
        test_random(PHASE_ITEMS, 0, 0);
        test_random(PHASE_ITEMS, 46, 0);
        test_random(PHASE_ITEMS, 0, 46);
        test_random(PHASE_ITEMS, 19, 19);
        cmd_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d commands (%0d results), memory preload, stack limits,",
                 sent, received);
        $display("%0d sprite draws and %0d stack faults under four idle/stall mixes",
                 draws, faults);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ chip8_instruction_execute.f @@
sv/c8ie_pkg.sv
sv/c8ie_if.sv
sv/c8ie_ram.sv
sv/c8ie_alu.sv
sv/chip8_instruction_execute.sv
tb/tb.sv
